// ===== hdl/vrft_pkg.sv =====
`default_nettype none
package vrft_pkg;

	localparam int CHUNK_WIDTH     = 16;
	localparam int CHUNK_HEIGHT    = 32;
	localparam int CHUNKS_PER_SIDE = 4;
	localparam int WINDOW_WIDTH    = CHUNK_WIDTH * CHUNKS_PER_SIDE;
	localparam int STORE_DEPTH     = WINDOW_WIDTH * CHUNK_HEIGHT * WINDOW_WIDTH;
	localparam int ADDR_W          = $clog2(STORE_DEPTH);

	localparam int COORD_W  = 6;
	localparam int ID_W     = 8;
	localparam int POS_W    = 24;
	localparam int DIR_W    = 16;
	localparam int LEN_W    = 20;
	localparam int FRAC_POS = 12;
	localparam int FRAC_DIR = 14;

	localparam int PLANE_W = 14;
	localparam int END_W   = 25;
	localparam int N_W     = 27;
	localparam int MA_W    = 27;
	localparam int MB_W    = 21;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int NUM_W   = SUM_W - FRAC_POS;
	localparam int DEN_W   = DIR_W;
	localparam int REM_W   = COORD_W + DEN_W;
	localparam int CNT_W   = $clog2(COORD_W + 1);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_TRACE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_WR_DONE  = 2'd0,
		STAT_WR_RANGE = 2'd1,
		STAT_HIT      = 2'd2,
		STAT_MISS     = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_END_MUL,
		ST_END_ADD,
		ST_AXIS_INIT,
		ST_PLANE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_DIV,
		ST_READ,
		ST_CHECK,
		ST_RANK,
		ST_RANK_M1,
		ST_RANK_M2,
		ST_RANK_CMP,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               done;
		logic               in_range;
		logic [COORD_W-1:0] quo;
	} div_res_t;

	function automatic logic [ADDR_W-1:0] vox_addr(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		int acc;
		acc = int'(y) * WINDOW_WIDTH * WINDOW_WIDTH + int'(z) * WINDOW_WIDTH + int'(x);
		return ADDR_W'(acc);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/voxel_ray_face_trace.sv =====
`default_nettype none
// Voxel store with ray trace. After reset the store is swept to air, one voxel per
// cycle, with in_ready low.
// A trace transaction walks the grid planes of x, y and z in turn: each plane whose
// own coordinate falls outside the window, or that lies behind the start, is
// skipped, and each plane inside it takes two shared-multiplier passes and a divide
// per other axis, then one store read, so the time a trace takes is set by how many
// planes the ray crosses. Results wait in an output register, so a new transaction
// can be taken while the last result is still unread.
module voxel_ray_face_trace (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [vrft_pkg::COORD_W-1:0]       voxel_x,
	input  logic [vrft_pkg::COORD_W-1:0]       voxel_y,
	input  logic [vrft_pkg::COORD_W-1:0]       voxel_z,
	input  logic [vrft_pkg::ID_W-1:0]          block_id,
	input  logic signed [vrft_pkg::POS_W-1:0]  start_x,
	input  logic signed [vrft_pkg::POS_W-1:0]  start_y,
	input  logic signed [vrft_pkg::POS_W-1:0]  start_z,
	input  logic signed [vrft_pkg::DIR_W-1:0]  dir_x,
	input  logic signed [vrft_pkg::DIR_W-1:0]  dir_y,
	input  logic signed [vrft_pkg::DIR_W-1:0]  dir_z,
	input  logic [vrft_pkg::LEN_W-1:0]         ray_length,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic [vrft_pkg::COORD_W-1:0]       hit_x,
	output logic [vrft_pkg::COORD_W-1:0]       hit_y,
	output logic [vrft_pkg::COORD_W-1:0]       hit_z,
	output logic [2:0]                         hit_face
);
	import vrft_pkg::*;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;

	cmd_t cmd_q;
	logic wr_range_q;
	logic signed [POS_W-1:0] sx_q, sy_q, sz_q;
	logic signed [DIR_W-1:0] dx_q, dy_q, dz_q;
	logic [LEN_W-1:0] len_q;
	logic signed [END_W-1:0] ex_q, ey_q, ez_q;
	logic [1:0] a_q;
	logic bsel_q, up_q;
	logic signed [PLANE_W-1:0] p_q, last_q;
	logic signed [N_W-1:0] n_q;
	logic [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic best_v_q, best_neg_q;
	logic [1:0] best_a_q;
	logic [COORD_W-1:0] bx_q, by_q, bz_q;
	logic [N_W-2:0] best_n_q;
	logic signed [PROD_W-1:0] prod1_q;

	logic out_valid_q;
	status_t status_q;
	logic [COORD_W-1:0] hx_q, hy_q, hz_q;
	logic [2:0] face_q;

	logic acc, wr_ok, load_out;
	logic signed [POS_W-1:0] s_a, s_b;
	logic signed [DIR_W-1:0] d_a, d_b, d_best;
	logic signed [END_W-1:0] e_a;
	logic [1:0] bidx;
	logic dir_neg, dir_zero;
	logic signed [PLANE_W-1:0] p0, last0, p_next, blk_a;
	logic up0, in_loop, blk_ok, n_bad, plane_go;
	logic signed [PLANE_W+FRAC_POS-1:0] pfix;
	logic signed [N_W-1:0] n_c;
	logic [N_W-2:0] abs_n;
	logic [DIR_W-1:0] abs_da, abs_db;
	logic signed [SUM_W-1:0] sum_c, num_c;
	logic coord_ok, rank_win;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	div_res_t div_res;
	logic div_start;
	logic ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [ID_W-1:0] ram_wdata, ram_rdata;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign wr_ok    = (int'(voxel_x) < WINDOW_WIDTH) && (int'(voxel_y) < CHUNK_HEIGHT) &&
		(int'(voxel_z) < WINDOW_WIDTH);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// the two other axes of a, in ascending order
	assign bidx = bsel_q ? ((a_q == AXIS_Z) ? AXIS_Y : AXIS_Z)
		: ((a_q == AXIS_X) ? AXIS_Y : AXIS_X);

	always_comb begin
		case (a_q)
			AXIS_X: begin s_a = sx_q; d_a = dx_q; e_a = ex_q; end
			AXIS_Y: begin s_a = sy_q; d_a = dy_q; e_a = ey_q; end
			default: begin s_a = sz_q; d_a = dz_q; e_a = ez_q; end
		endcase
		case (bidx)
			AXIS_X: begin s_b = sx_q; d_b = dx_q; end
			AXIS_Y: begin s_b = sy_q; d_b = dy_q; end
			default: begin s_b = sz_q; d_b = dz_q; end
		endcase
		case (best_a_q)
			AXIS_X: d_best = dx_q;
			AXIS_Y: d_best = dy_q;
			default: d_best = dz_q;
		endcase
	end

	assign dir_neg  = d_a[DIR_W-1];
	assign dir_zero = (d_a == '0);
	assign abs_da   = dir_neg ? DIR_W'(-d_a) : DIR_W'(d_a);
	assign abs_db   = d_best[DIR_W-1] ? DIR_W'(-d_best) : DIR_W'(d_best);

	// ceil and floor of the plane index, walk direction
	assign p0    = PLANE_W'(s_a >>> FRAC_POS) + PLANE_W'(|s_a[FRAC_POS-1:0]);
	assign last0 = PLANE_W'(e_a >>> FRAC_POS);
	assign up0   = END_W'(s_a) < e_a;

	assign in_loop = up_q ? (p_q <= last_q) : (p_q >= last_q);
	assign p_next  = up_q ? p_q + 1'b1 : p_q - 1'b1;
	assign pfix    = {p_q, FRAC_POS'(0)};
	assign n_c     = N_W'(pfix) - N_W'(s_a);
	assign n_bad   = (n_c[N_W-1] && !dir_neg) || (!n_c[N_W-1] && (n_c != '0) && dir_neg);
	assign blk_a   = dir_neg ? p_q - 1'b1 : p_q;
	assign blk_ok  = !blk_a[PLANE_W-1] &&
		(int'(blk_a) < ((a_q == AXIS_Y) ? CHUNK_HEIGHT : WINDOW_WIDTH));
	assign plane_go = in_loop && !n_bad && blk_ok;
	assign abs_n   = n_q[N_W-1] ? (N_W-1)'(-n_q) : n_q[N_W-2:0];

	// floor division by 4096*d_a: fold sign of d_a into the numerator
	assign sum_c    = SUM_W'(prod1_q) + SUM_W'(mul_p);
	assign num_c    = dir_neg ? -sum_c : sum_c;
	assign div_start = (state_q == ST_SUM);
	assign coord_ok = div_res.in_range &&
		(int'(div_res.quo) < ((bidx == AXIS_Y) ? CHUNK_HEIGHT : WINDOW_WIDTH));
	assign rank_win = (prod1_q <= mul_p);

	always_comb begin
		case (state_q)
			ST_END_MUL: begin
				mul_a = MA_W'(d_a);
				mul_b = MB_W'($signed({1'b0, len_q}));
			end
			ST_MUL1: begin
				mul_a = MA_W'(s_b);
				mul_b = MB_W'(d_a);
			end
			ST_MUL2: begin
				mul_a = MA_W'(n_q);
				mul_b = MB_W'(d_b);
			end
			ST_RANK_M1: begin
				mul_a = $signed({1'b0, abs_n});
				mul_b = MB_W'($signed({1'b0, abs_db}));
			end
			ST_RANK_M2: begin
				mul_a = $signed({1'b0, best_n_q});
				mul_b = MB_W'($signed({1'b0, abs_da}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	vrft_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	vrft_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_c[SUM_W-1:FRAC_POS]),
		.den    (abs_da),
		.res    (div_res)
	);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_addr  = clr_q;
			ram_we    = 1'b1;
			ram_wdata = '0;
		end else if (state_q == ST_READ) begin
			ram_addr  = vox_addr(cx_q, cy_q, cz_q);
			ram_we    = 1'b0;
			ram_wdata = block_id;
		end else begin
			ram_addr  = vox_addr(voxel_x, voxel_y, voxel_z);
			ram_we    = acc && (command == CMD_WRITE) && wr_ok;
			ram_wdata = block_id;
		end
	end

	vrft_ram #(
		.WIDTH (ID_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) state_d = (command == CMD_WRITE) ? ST_DONE : ST_END_MUL;
			end
			ST_END_MUL: state_d = ST_END_ADD;
			ST_END_ADD: state_d = (a_q == AXIS_Z) ? ST_AXIS_INIT : ST_END_MUL;
			ST_AXIS_INIT: state_d = dir_zero ? ST_NEXT : ST_PLANE;
			ST_PLANE: begin
				if (!in_loop) state_d = ST_NEXT;
				else if (plane_go) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_SUM;
			ST_SUM: state_d = ST_DIV;
			ST_DIV: begin
				if (div_res.done) begin
					if (!coord_ok) state_d = ST_PLANE;
					else state_d = bsel_q ? ST_READ : ST_MUL1;
				end
			end
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: state_d = (ram_rdata != '0) ? ST_RANK : ST_PLANE;
			ST_RANK: state_d = best_v_q ? ST_RANK_M1 : ST_NEXT;
			ST_RANK_M1: state_d = ST_RANK_M2;
			ST_RANK_M2: state_d = ST_RANK_CMP;
			ST_RANK_CMP: state_d = ST_NEXT;
			ST_NEXT: state_d = (a_q == AXIS_Z) ? ST_DONE : ST_AXIS_INIT;
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd_q      <= cmd_t'(command);
					wr_range_q <= !wr_ok;
					sx_q <= start_x; sy_q <= start_y; sz_q <= start_z;
					dx_q <= dir_x; dy_q <= dir_y; dz_q <= dir_z;
					len_q    <= ray_length;
					a_q      <= AXIS_X;
					best_v_q <= 1'b0;
				end
			end
			ST_END_ADD: begin
				case (a_q)
					AXIS_X: ex_q <= END_W'(s_a) + $signed(mul_p[FRAC_DIR+END_W-1:FRAC_DIR]);
					AXIS_Y: ey_q <= END_W'(s_a) + $signed(mul_p[FRAC_DIR+END_W-1:FRAC_DIR]);
					default: ez_q <= END_W'(s_a) + $signed(mul_p[FRAC_DIR+END_W-1:FRAC_DIR]);
				endcase
				a_q <= (a_q == AXIS_Z) ? AXIS_X : a_q + 1'b1;
			end
			ST_AXIS_INIT: begin
				p_q    <= p0;
				last_q <= last0;
				up_q   <= up0;
			end
			ST_PLANE: begin
				if (plane_go) begin
					n_q    <= n_c;
					bsel_q <= 1'b0;
					case (a_q)
						AXIS_X: cx_q <= blk_a[COORD_W-1:0];
						AXIS_Y: cy_q <= blk_a[COORD_W-1:0];
						default: cz_q <= blk_a[COORD_W-1:0];
					endcase
				end else if (in_loop) begin
					p_q <= p_next;
				end
			end
			ST_MUL2: prod1_q <= mul_p;
			ST_DIV: begin
				if (div_res.done) begin
					if (coord_ok) begin
						bsel_q <= 1'b1;
						case (bidx)
							AXIS_X: cx_q <= div_res.quo;
							AXIS_Y: cy_q <= div_res.quo;
							default: cz_q <= div_res.quo;
						endcase
					end else begin
						p_q <= p_next;
					end
				end
			end
			ST_CHECK: begin
				if (ram_rdata == '0) p_q <= p_next;
			end
			ST_RANK_M2: prod1_q <= mul_p;
			ST_NEXT: a_q <= a_q + 1'b1;
			default: ;
		endcase
		// a nearer current axis hit replaces the best one, later axes win ties
		if ((state_q == ST_RANK && !best_v_q) || (state_q == ST_RANK_CMP && rank_win)) begin
			best_v_q   <= 1'b1;
			best_a_q   <= a_q;
			best_neg_q <= dir_neg;
			best_n_q   <= abs_n;
			bx_q <= cx_q; by_q <= cy_q; bz_q <= cz_q;
		end
		if (load_out) begin
			if (cmd_q == CMD_WRITE) begin
				status_q <= wr_range_q ? STAT_WR_RANGE : STAT_WR_DONE;
			end else begin
				status_q <= best_v_q ? STAT_HIT : STAT_MISS;
			end
			if (cmd_q == CMD_TRACE && best_v_q) begin
				hx_q <= bx_q; hy_q <= by_q; hz_q <= bz_q;
				face_q <= {best_a_q, !best_neg_q};
			end else begin
				hx_q <= '0; hy_q <= '0; hz_q <= '0;
				face_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign hit_x     = hx_q;
	assign hit_y     = hy_q;
	assign hit_z     = hz_q;
	assign hit_face  = face_q;

	a_store_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("store written during a trace");

	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_HIT) |->
		(hit_x == '0 && hit_y == '0 && hit_z == '0 && hit_face == '0))
		else $error("non-hit result carries coordinates");

	a_hit_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_HIT) |->
		(hit_face <= 3'd5 && int'(hit_y) < CHUNK_HEIGHT))
		else $error("hit outside window");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid)
		else $error("result during clearing sweep");
endmodule
`default_nettype wire

// ===== hdl/vrft_ram.sv =====
`default_nettype none
module vrft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== hdl/vrft_mul.sv =====
`default_nettype none
module vrft_mul (
	input  logic                               clk,
	input  logic signed [vrft_pkg::MA_W-1:0]   a,
	input  logic signed [vrft_pkg::MB_W-1:0]   b,
	output logic signed [vrft_pkg::PROD_W-1:0] p
);
	import vrft_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;
endmodule
`default_nettype wire

// ===== hdl/vrft_div.sv =====
`default_nettype none
module vrft_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [vrft_pkg::NUM_W-1:0] num,
	input  logic [vrft_pkg::DEN_W-1:0]       den,
	output vrft_pkg::div_res_t               res
);
	import vrft_pkg::*;

	logic [REM_W-1:0]   rem_q;
	logic [REM_W-2:0]   dsh_q;
	logic [COORD_W-1:0] quo_q;
	logic               range_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [REM_W-1:0]   lim;
	logic               fits;

	// quotient must land in one coordinate width, checked up front
	assign lim  = {den, COORD_W'(0)};
	assign fits = !num[NUM_W-1] && (num[NUM_W-2:REM_W] == '0) && (num[REM_W-1:0] < lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			range_q <= fits;
			rem_q   <= num[REM_W-1:0];
			dsh_q   <= {den, (COORD_W-1)'(0)};
			quo_q   <= '0;
		end else if (busy_q) begin
			if (rem_q >= {1'b0, dsh_q}) begin
				rem_q <= rem_q - {1'b0, dsh_q};
				quo_q <= {quo_q[COORD_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[COORD_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign res = '{done: done_q, in_range: range_q, quo: quo_q};
endmodule
`default_nettype wire
